### src/stt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, codes and character classes of the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int TEXT_BUFFER_BYTES = 1024;
  localparam int TextCountW = $clog2(TEXT_BUFFER_BYTES);
  localparam logic [TextCountW-1:0] TextLimit = TextCountW'(TEXT_BUFFER_BYTES - 1);

  localparam logic [2:0] KIND_IDENT  = 3'd0;
  localparam logic [2:0] KIND_NUMBER = 3'd1;
  localparam logic [2:0] KIND_STRING = 3'd2;
  localparam logic [2:0] KIND_SYMBOL = 3'd3;
  localparam logic [2:0] KIND_EOF    = 3'd4;

  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_HASH    = 8'h23;
  localparam logic [7:0] CHAR_QUOTE   = 8'h22;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_IDENT   = 5'b00010,
    MODE_NUMBER  = 5'b00100,
    MODE_STRING  = 5'b01000,
    MODE_COMMENT = 5'b10000
  } lex_mode_e;

  typedef struct packed {
    logic [2:0] token_kind;
    logic [7:0] token_char;
    logic       char_valid;
    logic       token_end;
    logic       final_for_item;
  } result_t;

  typedef struct packed {
    result_t [1:0] res;
    logic [1:0]    count;
  } pair_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b inside {[8'h09:8'h0D]});
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return (b inside {[8'h61:8'h7A]}) || (b inside {[8'h41:8'h5A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic result_t mk_result(input logic [2:0] kind, input logic [7:0] ch,
                                        input logic valid, input logic tend);
    result_t r;
    r.token_kind     = kind;
    r.token_char     = ch;
    r.char_valid     = valid;
    r.token_end      = tend;
    r.final_for_item = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

### src/stt_intf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stt_in_if / stt_out_if
// Valid/ready channels for source bytes and token results.
// ----------------------------------------------------------------------------
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_input;

  modport source (output valid, output source_byte, output end_of_input, input ready);
  modport sink (input valid, input source_byte, input end_of_input, output ready);
endinterface

interface stt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [7:0] token_char;
  logic       char_valid;
  logic       token_end;
  logic       final_for_item;

  modport source (output valid, output token_kind, output token_char, output char_valid,
                  output token_end, output final_for_item, input ready);
  modport sink (input valid, input token_kind, input token_char, input char_valid,
                input token_end, input final_for_item, output ready);
endinterface
`default_nettype wire

### src/stt_lexer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stt_lexer
// Input register, lexing mode and text count; classifies one byte into up
// to two results and hands them on when the result buffer can take them.
// ----------------------------------------------------------------------------
module stt_lexer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  stt_in_if.sink           in_i,
  input  wire logic        load_ready_i,
  output logic             load_o,
  output stt_pkg::pair_t   pair_o
);
  import stt_pkg::*;

  logic                  in_valid_q;
  logic [7:0]            byte_q;
  logic                  eoi_q;
  lex_mode_e             mode_q, mode_d;
  logic [TextCountW-1:0] cnt_q, cnt_d;

  result_t               st_res;
  logic                  st_emit;
  lex_mode_e             st_mode;
  logic [TextCountW-1:0] st_cnt;
  result_t               r0, r1, ch_res;
  logic [1:0]            n;
  logic                  restart;
  logic                  text_emit;
  logic                  take;

  assign take       = in_valid_q & load_ready_i;
  assign in_i.ready = ~in_valid_q | load_ready_i;
  assign load_o     = take;

  // byte seen from idle, or the byte that ends an identifier or number
  always_comb begin
    st_res  = mk_result(KIND_SYMBOL, byte_q, 1'b1, 1'b1);
    st_emit = 1'b0;
    st_mode = MODE_IDLE;
    st_cnt  = '0;
    if (is_ws(byte_q)) begin
      st_mode = MODE_IDLE;
    end else if (is_letter(byte_q)) begin
      st_mode = MODE_IDENT;
      st_res  = mk_result(KIND_IDENT, byte_q, 1'b1, 1'b0);
      st_emit = 1'b1;
      st_cnt  = TextCountW'(1);
    end else if (is_digit(byte_q) || byte_q == CHAR_DOT) begin
      st_mode = MODE_NUMBER;
      st_res  = mk_result(KIND_NUMBER, byte_q, 1'b1, 1'b0);
      st_emit = 1'b1;
      st_cnt  = TextCountW'(1);
    end else if (byte_q == CHAR_QUOTE) begin
      st_mode = MODE_STRING;
    end else if (byte_q == CHAR_HASH) begin
      st_mode = MODE_COMMENT;
    end else begin
      st_mode = MODE_IDLE;
      st_emit = 1'b1;
    end
  end

  assign text_emit = cnt_q < TextLimit;

  always_comb begin
    r0      = '0;
    r1      = '0;
    n       = 2'd0;
    restart = 1'b0;
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    ch_res  = mk_result(KIND_IDENT, byte_q, 1'b1, 1'b0);
    if (eoi_q) begin
      mode_d = MODE_IDLE;
      cnt_d  = '0;
      case (mode_q)
        MODE_IDENT: begin
          r0 = mk_result(KIND_IDENT, 8'h00, 1'b0, 1'b1);
          r1 = mk_result(KIND_EOF, 8'h00, 1'b0, 1'b1);
          n  = 2'd2;
        end
        MODE_NUMBER: begin
          r0 = mk_result(KIND_NUMBER, 8'h00, 1'b0, 1'b1);
          r1 = mk_result(KIND_EOF, 8'h00, 1'b0, 1'b1);
          n  = 2'd2;
        end
        MODE_STRING: begin
          r0 = mk_result(KIND_STRING, 8'h00, 1'b0, 1'b1);
          r1 = mk_result(KIND_EOF, 8'h00, 1'b0, 1'b1);
          n  = 2'd2;
        end
        default: begin
          r0 = mk_result(KIND_EOF, 8'h00, 1'b0, 1'b1);
          n  = 2'd1;
        end
      endcase
    end else begin
      case (mode_q)
        MODE_IDENT: begin
          if (is_letter(byte_q) || is_digit(byte_q)) begin
            ch_res = mk_result(KIND_IDENT, byte_q, 1'b1, 1'b0);
            if (text_emit) begin
              r0    = ch_res;
              n     = 2'd1;
              cnt_d = cnt_q + TextCountW'(1);
            end
          end else begin
            r0      = mk_result(KIND_IDENT, 8'h00, 1'b0, 1'b1);
            n       = 2'd1;
            restart = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit(byte_q) || byte_q == CHAR_DOT) begin
            ch_res = mk_result(KIND_NUMBER, byte_q, 1'b1, 1'b0);
            if (text_emit) begin
              r0    = ch_res;
              n     = 2'd1;
              cnt_d = cnt_q + TextCountW'(1);
            end
          end else begin
            r0      = mk_result(KIND_NUMBER, 8'h00, 1'b0, 1'b1);
            n       = 2'd1;
            restart = 1'b1;
          end
        end
        MODE_STRING: begin
          if (byte_q == CHAR_QUOTE) begin
            r0     = mk_result(KIND_STRING, 8'h00, 1'b0, 1'b1);
            n      = 2'd1;
            mode_d = MODE_IDLE;
            cnt_d  = '0;
          end else begin
            ch_res = mk_result(KIND_STRING, byte_q, 1'b1, 1'b0);
            if (text_emit) begin
              r0    = ch_res;
              n     = 2'd1;
              cnt_d = cnt_q + TextCountW'(1);
            end
          end
        end
        MODE_COMMENT: begin
          if (byte_q == CHAR_NEWLINE) begin
            mode_d = MODE_IDLE;
            cnt_d  = '0;
          end
        end
        default: begin
          restart = 1'b1;
        end
      endcase
      if (restart) begin
        mode_d = st_mode;
        cnt_d  = st_cnt;
        if (st_emit) begin
          if (n == 2'd0) begin
            r0 = st_res;
          end else begin
            r1 = st_res;
          end
          n = n + 2'd1;
        end
      end
    end
    if (n == 2'd1) begin
      r0.final_for_item = 1'b1;
    end
    if (n == 2'd2) begin
      r1.final_for_item = 1'b1;
    end
  end

  assign pair_o.res[0] = r0;
  assign pair_o.res[1] = r1;
  assign pair_o.count  = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      mode_q     <= MODE_IDLE;
      cnt_q      <= '0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (take) begin
        in_valid_q <= 1'b0;
      end
      if (take) begin
        mode_q <= mode_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.source_byte;
      eoi_q  <= in_i.end_of_input;
    end
  end

endmodule
`default_nettype wire

### src/stt_result_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stt_result_buf
// Holds the results of one byte and sends them out one transfer at a time.
// ----------------------------------------------------------------------------
module stt_result_buf (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire stt_pkg::pair_t pair_i,
  output logic                load_ready_o,
  stt_out_if.source           out_o
);
  import stt_pkg::*;

  result_t    res_q [2];
  logic [1:0] cnt_q;
  logic       head_q;
  logic       pop;
  result_t    cur;

  assign cur          = res_q[head_q];
  assign out_o.valid  = cnt_q != 2'd0;
  assign pop          = out_o.valid & out_o.ready;
  assign load_ready_o = (cnt_q == 2'd0) | ((cnt_q == 2'd1) & out_o.ready);

  assign out_o.token_kind     = cur.token_kind;
  assign out_o.token_char     = cur.token_char;
  assign out_o.char_valid     = cur.char_valid;
  assign out_o.token_end      = cur.token_end;
  assign out_o.final_for_item = cur.final_for_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      head_q <= 1'b0;
    end else if (load_i) begin
      cnt_q  <= pair_i.count;
      head_q <= 1'b0;
    end else if (pop) begin
      cnt_q  <= cnt_q - 2'd1;
      head_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q[0] <= pair_i.res[0];
      res_q[1] <= pair_i.res[1];
    end
  end

endmodule
`default_nettype wire

### src/source_text_tokenizer.sv
`default_nettype none
// path: a byte waits in the input register until the result buffer loads its results
// throughput: one byte per cycle if each byte gives at most one result and out_o.ready;
//   a byte giving two holds the next back until one is sent (single result port)
// reset: mode idle, text count zero, input and result registers empty
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming tokenizer: one source byte in, token characters and end markers out.
// ----------------------------------------------------------------------------
module source_text_tokenizer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  stt_in_if.sink    in_i,
  stt_out_if.source out_o
);
  import stt_pkg::*;

  logic  load;
  logic  load_ready;
  pair_t pair;

  stt_lexer u_lexer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .load_ready_i (load_ready),
    .load_o       (load),
    .pair_o       (pair)
  );

  stt_result_buf u_result_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .pair_i       (pair),
    .load_ready_o (load_ready),
    .out_o        (out_o)
  );

`ifndef SYNTHESIS
  a_marker_ends_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.char_valid |-> out_o.token_end)
    else $error("result without character does not end a token");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.token_kind == KIND_EOF |-> out_o.final_for_item && out_o.token_end)
    else $error("end of file token is not the last result");

  a_symbol_whole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.token_kind == KIND_SYMBOL |-> out_o.char_valid && out_o.token_end)
    else $error("symbol token is not a single closed character");

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && out_o.valid && !(out_o.ready) |-> 1'b0)
    else $error("result buffer overwritten while holding a result");
`endif

endmodule
`default_nettype wire
